// File: rtl/m3inv_pkg.sv
package m3inv_pkg;

  localparam int IDX_W = 4;
  localparam int MAT_N = 9;

  typedef logic [IDX_W-1:0] idx_t;

  localparam idx_t LAST_IDX = 4'd8;
  localparam idx_t DET_LAST = 4'd2;

  // element pairs per adjugate entry: e[a]*e[b] - e[c]*e[d]
  localparam idx_t ADJ_POS [MAT_N][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COF_RD,
    ST_COF_MUL,
    ST_COF_ACC,
    ST_DET_RD,
    ST_DET_MUL,
    ST_DET_ACC,
    ST_DET_CHK,
    ST_RES_RD,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_OUT_LOAD,
    ST_OUT_WAIT
  } state_t;

  typedef enum logic [1:0] {
    MB_ELEM,
    MB_LO,
    MB_HI
  } mul_b_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_SUB,
    ACC_ADD,
    ACC_ADD_HI
  } acc_op_t;

  typedef struct packed {
    logic    wr_elem;
    idx_t    rd_a;
    idx_t    rd_b;
    idx_t    rd_adj;
    mul_b_t  mul_b;
    acc_op_t acc_op;
    logic    wr_adj;
    idx_t    wr_adj_addr;
    logic    div_load;
    logic    div_step;
    logic    out_load;
    logic    sing;
    idx_t    res_index;
  } dp_cmd_t;

  typedef struct packed {
    logic det_zero;
  } dp_stat_t;

endpackage

// File: rtl/m3inv_datapath.sv
module m3inv_datapath
  import m3inv_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic [WORD_BITS-1:0] in_value,
  input  idx_t                 in_index,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic [WORD_BITS-1:0] res_value,
  output idx_t                 res_index,
  output logic                 res_singular,
  output logic                 res_saturated,
  output logic                 res_last
);

  localparam int W     = WORD_BITS;
  localparam int ADJ_W = 2 * W + 1;
  localparam int PW    = 2 * W + 2;
  localparam int ACC_W = 3 * W + 2;
  localparam int NUM_W = ADJ_W + 2 * FRAC_BITS;
  localparam int HI_W  = NUM_W - W;
  localparam int REM_W = ((ACC_W > HI_W) ? ACC_W : HI_W) + 1;
  localparam logic [W-1:0] LIM = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]            elem_mem [MAT_N];
  logic signed [ADJ_W-1:0] adj_mem [MAT_N];
  logic signed [W-1:0]     ea_r;
  logic signed [W-1:0]     eb_r;
  logic signed [ADJ_W-1:0] adj_rd_r;

  logic signed [W:0]       mul_a;
  logic signed [W:0]       mul_b;
  logic signed [PW-1:0]    prod_r;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;

  logic [ADJ_W-1:0] adj_mag;
  logic [NUM_W-1:0] num;
  logic [ACC_W-1:0] den_mag;
  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] trial;
  logic             trial_ge;
  logic [W-1:0]     lo_r;
  logic [W-1:0]     q_r;
  logic [ACC_W-1:0] den_r;
  logic             neg_r;
  logic             ovf_r;

  logic [W-1:0] val;
  logic         sat;
  logic [W-1:0] res_value_r;
  idx_t         res_index_r;
  logic         res_singular_r;
  logic         res_saturated_r;
  logic         res_last_r;

  // storage
  always_ff @(posedge clk) begin
    if (cmd.wr_elem) begin
      elem_mem[in_index] <= in_value;
    end
    if (cmd.wr_adj) begin
      adj_mem[cmd.wr_adj_addr] <= acc_nxt[ADJ_W-1:0];
    end
    ea_r     <= elem_mem[cmd.rd_a];
    eb_r     <= elem_mem[cmd.rd_b];
    adj_rd_r <= adj_mem[cmd.rd_adj];
  end

  // shared multiplier
  assign mul_a = {ea_r[W-1], ea_r};

  always_comb begin
    case (cmd.mul_b)
      MB_ELEM: mul_b = {eb_r[W-1], eb_r};
      MB_LO:   mul_b = {1'b0, adj_rd_r[W-1:0]};
      MB_HI:   mul_b = adj_rd_r[ADJ_W-1:W];
      default: mul_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // accumulator
  assign prod_ext = ACC_W'(prod_r);

  always_comb begin
    case (cmd.acc_op)
      ACC_LOAD:   acc_nxt = prod_ext;
      ACC_SUB:    acc_nxt = acc_r - prod_ext;
      ACC_ADD:    acc_nxt = acc_r + prod_ext;
      ACC_ADD_HI: acc_nxt = acc_r + (prod_ext <<< W);
      default:    acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign stat.det_zero = (acc_r == '0);

  // restoring divider, one quotient bit per cycle
  assign adj_mag  = adj_rd_r[ADJ_W-1] ? -adj_rd_r : adj_rd_r;
  assign num      = {adj_mag, {(2*FRAC_BITS){1'b0}}};
  assign den_mag  = acc_r[ACC_W-1] ? -acc_r : acc_r;
  assign trial    = {rem_r[REM_W-2:0], lo_r[W-1]};
  assign trial_ge = (trial >= REM_W'(den_r));

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r <= REM_W'(num[NUM_W-1:W]);
      lo_r  <= num[W-1:0];
      q_r   <= '0;
      den_r <= den_mag;
      neg_r <= adj_rd_r[ADJ_W-1] ^ acc_r[ACC_W-1];
      ovf_r <= (REM_W'(num[NUM_W-1:W]) >= REM_W'(den_mag));
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? (trial - REM_W'(den_r)) : trial;
      lo_r  <= {lo_r[W-2:0], 1'b0};
      q_r   <= {q_r[W-2:0], trial_ge};
    end
  end

  // saturation and result register
  always_comb begin
    if (cmd.sing) begin
      sat = 1'b0;
      val = ea_r;
    end else if (neg_r) begin
      sat = ovf_r || (q_r > LIM);
      val = sat ? LIM : -q_r;
    end else begin
      sat = ovf_r || (q_r >= LIM);
      val = sat ? (LIM - 1'b1) : q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_value_r     <= val;
      res_index_r     <= cmd.res_index;
      res_singular_r  <= cmd.sing;
      res_saturated_r <= sat;
      res_last_r      <= (cmd.res_index == LAST_IDX);
    end
  end

  assign res_value     = res_value_r;
  assign res_index     = res_index_r;
  assign res_singular  = res_singular_r;
  assign res_saturated = res_saturated_r;
  assign res_last      = res_last_r;

endmodule

// File: rtl/m3inv_ctrl.sv
module m3inv_ctrl
  import m3inv_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  idx_t     in_index,
  output logic     in_tready,
  input  logic     out_tready,
  output logic     out_tvalid,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam int BIT_W = $clog2(WORD_BITS);

  state_t           state_r, state_nxt;
  idx_t             k_r, k_nxt;
  logic             p_r, p_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic             sing_r, sing_nxt;
  logic             in_fire;
  logic             out_fire;

  assign in_fire  = in_tvalid & in_tready;
  assign out_fire = out_tvalid & out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      p_r     <= 1'b0;
      bit_r   <= '0;
      sing_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      p_r     <= p_nxt;
      bit_r   <= bit_nxt;
      sing_r  <= sing_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    k_nxt           = k_r;
    p_nxt           = p_r;
    bit_nxt         = bit_r;
    sing_nxt        = sing_r;
    in_tready       = 1'b0;
    out_tvalid      = 1'b0;
    cmd             = '0;
    cmd.rd_a        = k_r;
    cmd.rd_b        = k_r;
    cmd.rd_adj      = k_r;
    cmd.mul_b       = MB_ELEM;
    cmd.acc_op      = ACC_HOLD;
    cmd.wr_adj_addr = k_r;
    cmd.sing        = sing_r;
    cmd.res_index   = k_r;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_fire && (in_index <= LAST_IDX)) begin
          cmd.wr_elem = 1'b1;
          if (in_index == LAST_IDX) begin
            state_nxt = ST_COF_RD;
            k_nxt     = '0;
            p_nxt     = 1'b0;
          end
        end
      end
      ST_COF_RD: begin
        cmd.rd_a  = ADJ_POS[k_r][{p_r, 1'b0}];
        cmd.rd_b  = ADJ_POS[k_r][{p_r, 1'b1}];
        state_nxt = ST_COF_MUL;
      end
      ST_COF_MUL: begin
        cmd.mul_b = MB_ELEM;
        state_nxt = ST_COF_ACC;
      end
      ST_COF_ACC: begin
        if (!p_r) begin
          cmd.acc_op = ACC_LOAD;
          p_nxt      = 1'b1;
          state_nxt  = ST_COF_RD;
        end else begin
          cmd.acc_op = ACC_SUB;
          cmd.wr_adj = 1'b1;
          p_nxt      = 1'b0;
          if (k_r == LAST_IDX) begin
            k_nxt     = '0;
            state_nxt = ST_DET_RD;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_COF_RD;
          end
        end
      end
      ST_DET_RD: begin
        cmd.rd_a   = k_r;
        cmd.rd_adj = k_r + (k_r << 1);
        state_nxt  = ST_DET_MUL;
      end
      ST_DET_MUL: begin
        cmd.mul_b = p_r ? MB_HI : MB_LO;
        state_nxt = ST_DET_ACC;
      end
      ST_DET_ACC: begin
        if (p_r) begin
          cmd.acc_op = ACC_ADD_HI;
          p_nxt      = 1'b0;
          if (k_r == DET_LAST) begin
            k_nxt     = '0;
            state_nxt = ST_DET_CHK;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_DET_RD;
          end
        end else begin
          cmd.acc_op = (k_r == '0) ? ACC_LOAD : ACC_ADD;
          p_nxt      = 1'b1;
          state_nxt  = ST_DET_RD;
        end
      end
      ST_DET_CHK: begin
        sing_nxt  = stat.det_zero;
        state_nxt = ST_RES_RD;
      end
      ST_RES_RD: begin
        state_nxt = sing_r ? ST_OUT_LOAD : ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        bit_nxt      = '0;
        state_nxt    = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        cmd.div_step = 1'b1;
        if (bit_r == BIT_W'(WORD_BITS - 1)) begin
          state_nxt = ST_OUT_LOAD;
        end else begin
          bit_nxt = bit_r + 1'b1;
        end
      end
      ST_OUT_LOAD: begin
        cmd.out_load = 1'b1;
        state_nxt    = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (k_r == LAST_IDX) begin
            k_nxt     = '0;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_RES_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and result channels open together");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_index == LAST_IDX)) |=> (state_r == ST_COF_RD))
    else $error("last element did not start inversion");

  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && (k_r == LAST_IDX)) |=> (state_r == ST_IDLE))
    else $error("no return to idle after last result");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_STEP) |-> (bit_r <= BIT_W'(WORD_BITS - 1)))
    else $error("divider bit counter out of range");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= LAST_IDX)
    else $error("element counter out of range");
`endif

endmodule

// File: rtl/matrix3x3_inverse.sv
// channel  dir  tdata (low bit up)                          tuser                 tlast
// in_      in   element_value, element_index                -                     -
// out_     out  result_value, result_index                  singular, saturated   last_result
//
// loading accepts one element per cycle; index 8 starts an inversion
// inversion: cofactors and then the determinant on the shared multiplier,
// a zero check, then per result a divide and an output load (no divide when singular),
// after which each result waits for out_tready
// no input is taken from index 8 until the ninth result has been transferred
// reset clears the controller only; the matrix store is not cleared
module matrix3x3_inverse
  import m3inv_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  input  logic [((WORD_BITS + IDX_W + 7) / 8) * 8-1:0] in_tdata,  // element_value, element_index
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  output logic [((WORD_BITS + IDX_W + 7) / 8) * 8-1:0] out_tdata, // result_value, result_index
  output logic [1:0]                                   out_tuser, // singular, saturated
  output logic                                         out_tlast
);

  localparam int DATA_W = ((WORD_BITS + IDX_W + 7) / 8) * 8;

  dp_cmd_t              cmd;
  dp_stat_t             stat;
  logic [WORD_BITS-1:0] res_value;
  idx_t                 res_index;
  logic                 res_singular;
  logic                 res_saturated;
  logic                 res_last;

  m3inv_ctrl #(
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_index   (in_tdata[WORD_BITS +: IDX_W]),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .stat       (stat),
    .cmd        (cmd)
  );

  m3inv_datapath #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk           (clk),
    .in_value      (in_tdata[WORD_BITS-1:0]),
    .in_index      (in_tdata[WORD_BITS +: IDX_W]),
    .cmd           (cmd),
    .stat          (stat),
    .res_value     (res_value),
    .res_index     (res_index),
    .res_singular  (res_singular),
    .res_saturated (res_saturated),
    .res_last      (res_last)
  );

  assign out_tdata = DATA_W'({res_index, res_value});
  assign out_tuser = {res_saturated, res_singular};
  assign out_tlast = res_last;

endmodule

// File: tb/sv/tb_matrix3x3_inverse.sv
`timescale 1ns / 100ps

module tb_matrix3x3_inverse;
  import m3inv_pkg::*;

  localparam int WB = 32;
  localparam int FB = 16;
  localparam int BUS_W = ((WB + IDX_W + 7) / 8) * 8;
  localparam int IDLE_LIMIT = 6000;
  localparam int HOLD_CYCLES = 500;

  typedef struct {
    logic [WB-1:0] value;
    idx_t          index;
    logic          singular;
    logic          saturated;
    logic          last;
  } inv_result_t;

  class inverse_scoreboard;
    logic [WB-1:0] elems[MAT_N];
    inv_result_t   pending_q[$];
    int            errors;

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    function void note_input(logic [WB-1:0] v, idx_t i);
      logic signed [255:0] e[MAT_N];
      logic signed [255:0] adj[MAT_N];
      logic signed [255:0] det, dmag, num, quo, lim;
      logic                sing, neg;
      inv_result_t         r;
      if (i > LAST_IDX) return;
      elems[i] = v;
      if (i != LAST_IDX) return;
      for (int k = 0; k < MAT_N; k++) e[k] = $signed(elems[k]);
      for (int k = 0; k < MAT_N; k++)
        adj[k] = e[ADJ_POS[k][0]] * e[ADJ_POS[k][1]] - e[ADJ_POS[k][2]] * e[ADJ_POS[k][3]];
      det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
      sing = (det == 0);
      dmag = (det < 0) ? -det : det;
      lim = 256'sd1 <<< (WB - 1);
      for (int k = 0; k < MAT_N; k++) begin
        r.index = idx_t'(k);
        r.singular = sing;
        r.saturated = 1'b0;
        r.last = (k == MAT_N - 1);
        if (sing) begin
          r.value = elems[k];
        end else begin
          num = ((adj[k] < 0) ? -adj[k] : adj[k]) <<< (2 * FB);
          quo = num / dmag;
          neg = (adj[k] < 0) != (det < 0);
          if (neg) begin
            if (quo > lim) begin
              quo = lim;
              r.saturated = 1'b1;
            end
            r.value = WB'(-quo);
          end else if (quo >= lim) begin
            r.saturated = 1'b1;
            r.value = {1'b0, {(WB-1){1'b1}}};
          end else begin
            r.value = WB'(quo);
          end
        end
        pending_q.push_back(r);
      end
    endfunction

    task check(logic [BUS_W-1:0] data, logic [1:0] user, logic last);
      inv_result_t w;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", 64'(data), 64'd0);
        return;
      end
      w = pending_q.pop_front();
      if (data[WB-1:0] !== w.value) report_mismatch("value", 64'(data[WB-1:0]), 64'(w.value));
      if (data[WB+IDX_W-1:WB] !== w.index)
        report_mismatch("index", 64'(data[WB+IDX_W-1:WB]), 64'(w.index));
      if (data[BUS_W-1:WB+IDX_W] !== '0)
        report_mismatch("tdata pad", 64'(data[BUS_W-1:WB+IDX_W]), 64'd0);
      if (user[0] !== w.singular) report_mismatch("singular", 64'(user[0]), 64'(w.singular));
      if (user[1] !== w.saturated) report_mismatch("saturated", 64'(user[1]), 64'(w.saturated));
      if (last !== w.last) report_mismatch("last", 64'(last), 64'(w.last));
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [BUS_W-1:0] in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [BUS_W-1:0] out_tdata;
  logic [1:0]       out_tuser;
  logic             out_tlast;

  inverse_scoreboard sb;
  int                idle_cycles;
  int                results_seen;
  int                sent;

  matrix3x3_inverse #(.WORD_BITS(WB), .FRAC_BITS(FB)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int random_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_element(input logic [WB-1:0] v, input idx_t i);
    int gap;
    gap = random_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= BUS_W'({i, v});
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  function automatic logic [WB-1:0] random_element();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return WB'($signed($urandom_range(0, 1048576)) - 524288);
    if (p < 80) return WB'($signed($urandom_range(0, 4096)) - 2048);
    if (p < 95) return $urandom;
    case ($urandom_range(0, 3))
      0: return {1'b1, {(WB-1){1'b0}}};
      1: return {1'b0, {(WB-1){1'b1}}};
      2: return '0;
      default: return '1;
    endcase
  endfunction

  task automatic send_random_matrix();
    logic [WB-1:0] m[MAT_N];
    int            order[8];
    int            j, t, p;
    for (int k = 0; k < MAT_N; k++) m[k] = random_element();
    p = $urandom_range(0, 99);
    if (p < 20) begin
      for (int k = 0; k < 3; k++) m[3 + k] = m[k];
    end else if (p < 25) begin
      for (int k = 0; k < 3; k++) m[3 * k + 2] = '0;
    end
    for (int k = 0; k < 8; k++) order[k] = k;
    for (int k = 7; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    t = ($urandom_range(0, 9) < 2) ? $urandom_range(0, 7) : 8;
    for (int k = 0; k < t; k++) begin
      if ($urandom_range(0, 19) == 0) send_element($urandom, idx_t'($urandom_range(9, 15)));
      send_element(m[order[k]], idx_t'(order[k]));
    end
    send_element(m[8], LAST_IDX);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata[WB-1:0], in_tdata[WB+IDX_W-1:WB]);
    if (rst_n && out_tvalid && out_tready) begin
      sb.check(out_tdata, out_tuser, out_tlast);
      results_seen++;
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int  stall;
    bit  held;
    held = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!held && results_seen >= 60) begin
        held = 1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = random_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  initial begin
    sb = new();
    idle_cycles = 0;
    results_seen = 0;
    sent = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity
    for (int k = 0; k < MAT_N; k++)
      send_element((k % 4 == 0) ? WB'(32'h0001_0000) : '0, idx_t'(k));
    // tiny diagonal drives positive saturation
    send_element(WB'(1), 4'd0);
    send_element(WB'(1), 4'd4);
    send_element(WB'(1), LAST_IDX);
    // negative saturation
    send_element('1, 4'd0);
    send_element(WB'(1), LAST_IDX);
    // extremes of the element range
    send_element({1'b1, {(WB-1){1'b0}}}, 4'd0);
    send_element({1'b0, {(WB-1){1'b1}}}, 4'd4);
    send_element({1'b1, {(WB-1){1'b0}}}, LAST_IDX);
    // zero determinant echoes the matrix
    send_element('0, 4'd0);
    send_element(WB'(32'h0003_0000), LAST_IDX);
    // indices out of range are dropped
    for (int k = 9; k < 16; k++) send_element($urandom, idx_t'(k));

    while (sent < 200) send_random_matrix();

    @(posedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
